### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/wfs_pkg.sv
// ----------------------------------------------------------------------------
// wfs_pkg
// Types and constants shared by the frame serializer modules.
// ----------------------------------------------------------------------------
package wfs_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam logic [31:0] CAPACITY_RESET = 32'hFFFF_FFFF;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_PAYLOAD = 1'b1;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   localparam logic [3:0] SIZE_BYTES_16 = 4'd2;
   localparam logic [3:0] SIZE_BYTES_64 = 4'd8;
   localparam logic [3:0] KEY_BYTES     = 4'd4;
   localparam logic [3:0] BASE_BYTES    = 4'd2;

   typedef enum logic {
      CMD_HEADER = 1'b0,
      CMD_DATA   = 1'b1
   } cmd_kind_type;

   // One queued job for the back end: a whole header burst or one data byte.
   typedef struct packed {
      cmd_kind_type kind;
      logic         err;        // header ends in an error result
      logic         last;       // final emitted byte closes the frame
      logic [3:0]   n_emit;     // header bytes to send before stopping
      logic [3:0]   size_bytes; // extended size field length
      logic [7:0]   byte0;      // first header byte, or the data byte
      logic [7:0]   byte1;
      logic [62:0]  size;
      logic [31:0]  key;
   } cmd_type;

endpackage

### rtl/wfs_front.sv
// ----------------------------------------------------------------------------
// wfs_front
// Accepts requests, checks capacity, tracks the open frame and queues jobs.
// ----------------------------------------------------------------------------
module wfs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_operation,
   input  logic              req_fin,
   input  logic [3:0]        req_opcode,
   input  logic [6:0]        req_length_code,
   input  logic [62:0]       req_payload_size,
   input  logic              req_mask_enable,
   input  logic [31:0]       req_masking_key,
   input  logic [7:0]        req_payload_byte,
   input  logic              csr_write_en,
   input  logic [31:0]       csr_write_data,
   input  logic              q_full,
   output logic              q_push,
   output wfs_pkg::cmd_type  q_cmd
);
   import wfs_pkg::*;

   logic [31:0] capacity_ff, capacity_in;
   logic        open_ff, open_in;
   logic [62:0] remaining_ff, remaining_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] key_ff, key_in;
   logic        mask_ff, mask_in;

   logic        accept;
   logic [3:0]  size_bytes;
   logic [3:0]  total;
   logic [63:0] frame_total;
   logic        payload_fits;
   logic [3:0]  n_emit;
   logic        hdr_err;
   logic [7:0]  key_byte;
   logic [7:0]  data_byte;
   logic        data_last;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   always_comb begin
      priority if (req_length_code == LEN_CODE_64) begin
         size_bytes = SIZE_BYTES_64;
      end else if (req_length_code == LEN_CODE_16) begin
         size_bytes = SIZE_BYTES_16;
      end else begin
         size_bytes = '0;
      end
      total = BASE_BYTES + size_bytes + (req_mask_enable ? KEY_BYTES : 4'd0);
      frame_total  = {1'b0, req_payload_size} + {60'd0, total};
      payload_fits = frame_total <= {32'd0, capacity_ff};

      // Stop at the first field group that does not fit.
      priority if (capacity_ff == 32'd0) begin
         n_emit = 4'd0;
         hdr_err = 1'b1;
      end else if (capacity_ff == 32'd1) begin
         n_emit = 4'd1;
         hdr_err = 1'b1;
      end else if (size_bytes != 4'd0 && capacity_ff < {28'd0, BASE_BYTES + size_bytes}) begin
         n_emit = BASE_BYTES;
         hdr_err = 1'b1;
      end else if (req_mask_enable && capacity_ff < {28'd0, total}) begin
         n_emit = BASE_BYTES + size_bytes;
         hdr_err = 1'b1;
      end else if (req_payload_size != '0 && !payload_fits) begin
         n_emit = total;
         hdr_err = 1'b1;
      end else begin
         n_emit = total;
         hdr_err = 1'b0;
      end

      key_byte  = key_ff[{2'd3 - phase_ff, 3'b000} +: 8];
      data_byte = req_payload_byte ^ (mask_ff ? key_byte : 8'h00);
      data_last = remaining_ff == 63'd1;
   end

   always_comb begin
      capacity_in  = csr_write_en ? csr_write_data : capacity_ff;
      open_in      = open_ff;
      remaining_in = remaining_ff;
      phase_in     = phase_ff;
      key_in       = key_ff;
      mask_in      = mask_ff;
      q_push       = 1'b0;
      q_cmd        = '0;

      if (accept) begin
         unique case (req_operation)
            OP_START: begin
               q_push           = 1'b1;
               q_cmd.kind       = CMD_HEADER;
               q_cmd.err        = hdr_err;
               q_cmd.last       = !hdr_err && req_payload_size == '0;
               q_cmd.n_emit     = n_emit;
               q_cmd.size_bytes = size_bytes;
               q_cmd.byte0      = {req_fin, 3'b000, req_opcode};
               q_cmd.byte1      = {req_mask_enable, req_length_code};
               q_cmd.size       = req_payload_size;
               q_cmd.key        = req_masking_key;
               // An open frame is abandoned by a new start.
               open_in      = !hdr_err && req_payload_size != '0;
               remaining_in = open_in ? req_payload_size : '0;
               phase_in     = '0;
               key_in       = req_masking_key;
               mask_in      = req_mask_enable;
            end
            OP_PAYLOAD: begin
               // Drop payload outside an open frame.
               if (open_ff) begin
                  q_push       = 1'b1;
                  q_cmd.kind   = CMD_DATA;
                  q_cmd.last   = data_last;
                  q_cmd.byte0  = data_byte;
                  remaining_in = remaining_ff - 63'd1;
                  phase_in     = phase_ff + 2'd1;
                  open_in      = !data_last;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff  <= CAPACITY_RESET;
         open_ff      <= 1'b0;
         remaining_ff <= '0;
         phase_ff     <= '0;
         key_ff       <= '0;
         mask_ff      <= 1'b0;
      end else begin
         capacity_ff  <= capacity_in;
         open_ff      <= open_in;
         remaining_ff <= remaining_in;
         phase_ff     <= phase_in;
         key_ff       <= key_in;
         mask_ff      <= mask_in;
      end
   end

endmodule

### rtl/wfs_queue.sv
// ----------------------------------------------------------------------------
// wfs_queue
// Small job queue between the request front end and the byte back end.
// ----------------------------------------------------------------------------
module wfs_queue #(
   parameter int unsigned DEPTH = wfs_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  wfs_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output wfs_pkg::cmd_type  head_cmd
);
   import wfs_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = count_ff == CNT_FULL;
   assign empty    = count_ff == '0;
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### rtl/wfs_back.sv
// ----------------------------------------------------------------------------
// wfs_back
// Expands queued jobs into response bytes, one per cycle unless the output stage stalls.
// ----------------------------------------------------------------------------
module wfs_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  wfs_pkg::cmd_type  q_head,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_out_last,
   output logic              rsp_out_error
);
   import wfs_pkg::*;

   logic        busy_ff, busy_in;
   logic [3:0]  idx_ff, idx_in;
   cmd_type     cmd_ff, cmd_in;
   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic        error_ff, error_in;

   cmd_type     cur;
   logic [3:0]  idx;
   logic        advance;
   logic        done;
   logic [7:0]  item_byte;
   logic        item_last;
   logic        item_error;
   logic [7:0]  hdr_byte;
   logic [3:0]  size_idx;
   logic [3:0]  size_pos;
   logic [3:0]  key_idx;
   logic [63:0] size_word;

   assign rsp_empty     = !valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_out_last  = last_ff;
   assign rsp_out_error = error_ff;

   always_comb begin
      cur     = busy_ff ? cmd_ff : q_head;
      idx     = busy_ff ? idx_ff : 4'd0;
      advance = (busy_ff || !q_empty) && (!valid_ff || rsp_pop);
      q_pop   = advance && !busy_ff;

      size_word = {1'b0, cur.size};
      size_idx  = idx - BASE_BYTES;
      size_pos  = cur.size_bytes - 4'd1 - size_idx;
      key_idx   = idx - BASE_BYTES - cur.size_bytes;

      priority if (idx == 4'd0) begin
         hdr_byte = cur.byte0;
      end else if (idx == 4'd1) begin
         hdr_byte = cur.byte1;
      end else if (idx < BASE_BYTES + cur.size_bytes) begin
         hdr_byte = size_word[{size_pos[2:0], 3'b000} +: 8];
      end else begin
         hdr_byte = cur.key[{2'd3 - key_idx[1:0], 3'b000} +: 8];
      end

      unique case (cur.kind)
         CMD_DATA: begin
            item_byte  = cur.byte0;
            item_last  = cur.last;
            item_error = 1'b0;
            done       = 1'b1;
         end
         CMD_HEADER: begin
            if (idx == cur.n_emit) begin
               // Header bytes that fit are out; close the frame with the error.
               item_byte  = 8'h00;
               item_last  = 1'b1;
               item_error = 1'b1;
               done       = 1'b1;
            end else begin
               item_byte  = hdr_byte;
               item_last  = cur.last && idx == cur.n_emit - 4'd1;
               item_error = 1'b0;
               done       = !cur.err && idx == cur.n_emit - 4'd1;
            end
         end
         default: begin
            item_byte  = 8'h00;
            item_last  = 1'b0;
            item_error = 1'b0;
            done       = 1'b1;
         end
      endcase

      busy_in  = busy_ff;
      idx_in   = idx_ff;
      cmd_in   = cmd_ff;
      valid_in = valid_ff && !rsp_pop;
      byte_in  = byte_ff;
      last_in  = last_ff;
      error_in = error_ff;
      if (advance) begin
         busy_in  = !done;
         idx_in   = idx + 4'd1;
         cmd_in   = cur;
         valid_in = 1'b1;
         byte_in  = item_byte;
         last_in  = item_last;
         error_in = item_error;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
      error_ff <= error_in;
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/websocket_frame_serializer.sv
// ----------------------------------------------------------------------------
// websocket_frame_serializer
// Turns start and payload requests into a stream of frame bytes.
// ----------------------------------------------------------------------------
//  channel   | ports                        | transfer
//  ----------+------------------------------+----------------------------------
//  request   | req_push / req_full          | push && !full
//  response  | rsp_pop / rsp_empty          | pop && !empty
//  csr       | csr_write_en / csr_write_data| write_en, no wait
//
//  A request is taken whenever the job queue has room.
//  The back end sends one response byte per cycle unless the output stalls:
//  a start request yields 1 to 15 responses (header bytes, then an error if
//  one applies), a payload request one inside an open frame, none outside.
//  The queue (QUEUE_DEPTH jobs) lets requests run ahead of a stalled output.
//  Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module websocket_frame_serializer #(
   parameter int unsigned QUEUE_DEPTH = wfs_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_operation,
   input  logic        req_fin,
   input  logic [3:0]  req_opcode,
   input  logic [6:0]  req_length_code,
   input  logic [62:0] req_payload_size,
   input  logic        req_mask_enable,
   input  logic [31:0] req_masking_key,
   input  logic [7:0]  req_payload_byte,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_out_error,
   input  logic        csr_write_en,
   input  logic [31:0] csr_write_data
);
   import wfs_pkg::*;

   logic    q_full, q_push, q_empty, q_pop;
   cmd_type q_cmd, q_head;

   wfs_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_operation    (req_operation),
      .req_fin          (req_fin),
      .req_opcode       (req_opcode),
      .req_length_code  (req_length_code),
      .req_payload_size (req_payload_size),
      .req_mask_enable  (req_mask_enable),
      .req_masking_key  (req_masking_key),
      .req_payload_byte (req_payload_byte),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_cmd            (q_cmd)
   );

   wfs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   wfs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last),
      .rsp_out_error (rsp_out_error)
   );

endmodule

### rtl/wfs_checker.sv
// ----------------------------------------------------------------------------
// wfs_checker
// Port-level checks on the frame serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_out_last,
   input logic        rsp_out_error
);

   `ASSERT_CLK_ALWAYS(a_reset_empty, clock, reset |=> rsp_empty, "response pending after reset")

   `ASSERT_CLK_ALWAYS(a_reset_not_full, clock, reset |=> !req_full, "request side full after reset")

   `ASSERT_CLK(a_error_is_last, clock, reset, (!rsp_empty && rsp_out_error) |-> rsp_out_last, "error response does not end the frame")

   `ASSERT_CLK(a_error_zero_byte, clock, reset, (!rsp_empty && rsp_out_error) |-> (rsp_out_byte == 8'h00), "error response carries data")

   `ASSERT_CLK(a_stall_holds, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_out_byte) && $stable(rsp_out_last) && $stable(rsp_out_error)), "stalled response changed")

endmodule

bind websocket_frame_serializer wfs_checker u_checker (.*);
